/* sv/giq_pkg.sv */
// Shared constants, codes and the ring slot function of the grouped insert queue.
package giq_pkg;

    localparam int QUEUE_DEPTH  = 1024;
    localparam int MEMBER_DEPTH = 1024;

    localparam int ID_W     = 16;
    localparam int GRP_W    = 16;
    localparam int ENTRY_W  = ID_W + GRP_W;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW  = (MEMBER_DEPTH > 1) ? $clog2(MEMBER_DEPTH) : 1;
    localparam int MCW = $clog2(MEMBER_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_REG = 2'd0;
    localparam logic [OP_W-1:0] OP_ENQ = 2'd1;
    localparam logic [OP_W-1:0] OP_DEQ = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DEQUEUED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_QUEUE_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MEMBER_FULL = 3'd4;

    // Physical slot of a logical queue position; head + pos stays below twice the depth.
    function automatic logic [QW-1:0] slot_of(input logic [QW-1:0] head,
                                              input logic [QCW-1:0] pos);
        logic [QCW:0] s;
        s = (QCW+1)'(head) + (QCW+1)'(pos);
        if (s >= (QCW+1)'(QUEUE_DEPTH)) begin
            s = s - (QCW+1)'(QUEUE_DEPTH);
        end
        return s[QW-1:0];
    endfunction

endpackage

/* sv/giq_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module giq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* sv/grouped_insert_queue.sv */
// Grouped insert queue: member table, group lookup and ordered insertion in a ring store.
// Register writes the member table from idle; dequeue reads the head slot in S_DEQ. Enqueue
// scans the member table in S_LOOK, then searches the queue backward for its group in
// S_QSRCH and shifts the later entries in S_SHIFT, one entry per cycle, as each
// store has a single read port. The result strobe is registered from the deciding state.
// Synchronous active-low reset empties both tables at once; no clearing pass is needed.
module grouped_insert_queue import giq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [ID_W-1:0]     i_member_id,
    input  logic [GRP_W-1:0]    i_group_id,
    output logic                busy,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_out_id
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_QSRCH = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DEQ   = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [MCW-1:0]      r_mcount, n_mcount;
    logic [QW-1:0]       r_qhead, n_qhead;
    logic [QCW-1:0]      r_qcount, n_qcount;
    logic [ID_W-1:0]     r_id, n_id;
    logic [GRP_W-1:0]    r_grp, n_grp;
    logic [MCW-1:0]      r_ra, n_ra;
    logic                r_pend, n_pend;
    logic                r_last, n_last;
    logic [QCW-1:0]      r_k, n_k;
    logic [QCW-1:0]      r_pk, n_pk;
    logic [QCW-1:0]      r_pos, n_pos;
    logic [QW-1:0]       r_dst, n_dst;
    logic                r_valid, n_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [ID_W-1:0]     r_out_id, n_out_id;

    logic                m_we;
    logic [MW-1:0]       m_waddr;
    logic [ENTRY_W-1:0]  m_wdata;
    logic [MW-1:0]       m_raddr;
    logic [ENTRY_W-1:0]  m_rdata;
    logic                q_we;
    logic [QW-1:0]       q_waddr;
    logic [ENTRY_W-1:0]  q_wdata;
    logic [QW-1:0]       q_raddr;
    logic [ENTRY_W-1:0]  q_rdata;
    logic [QCW-1:0]      k_dec;

    assign k_dec = r_k - QCW'(1);

    always_comb begin
        n_state  = r_state;
        n_mcount = r_mcount;
        n_qhead  = r_qhead;
        n_qcount = r_qcount;
        n_id     = r_id;
        n_grp    = r_grp;
        n_ra     = r_ra;
        n_pend   = 1'b0;
        n_last   = 1'b0;
        n_k      = r_k;
        n_pk     = r_pk;
        n_pos    = r_pos;
        n_dst    = r_dst;
        n_valid  = 1'b0;
        n_status = r_status;
        n_out_id = r_out_id;
        m_we     = 1'b0;
        m_waddr  = r_mcount[MW-1:0];
        m_wdata  = {i_member_id, i_group_id};
        m_raddr  = r_ra[MW-1:0];
        q_we     = 1'b0;
        q_waddr  = r_dst;
        q_wdata  = q_rdata;
        q_raddr  = r_qhead;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_id = i_member_id;
                    unique case (i_opcode)
                        OP_REG: begin
                            if (r_mcount == MCW'(MEMBER_DEPTH)) begin
                                n_valid  = 1'b1;
                                n_status = ST_MEMBER_FULL;
                                n_out_id = '0;
                            end else begin
                                m_we     = 1'b1;
                                n_mcount = r_mcount + MCW'(1);
                            end
                        end
                        OP_ENQ: begin
                            if (r_mcount == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_UNKNOWN;
                                n_out_id = '0;
                            end else begin
                                n_ra    = '0;
                                n_state = S_LOOK;
                            end
                        end
                        OP_DEQ: begin
                            if (r_qcount == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                                n_out_id = '0;
                            end else begin
                                n_state = S_DEQ;
                            end
                        end
                        OP_NOP: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                n_ra   = r_ra + MCW'(1);
                n_pend = (r_ra < r_mcount);
                n_last = (r_ra == r_mcount - MCW'(1));
                if (r_pend && (m_rdata[ENTRY_W-1:GRP_W] == r_id)) begin
                    n_grp  = m_rdata[GRP_W-1:0];
                    n_pend = 1'b0;
                    if (r_qcount == QCW'(QUEUE_DEPTH)) begin
                        n_valid  = 1'b1;
                        n_status = ST_QUEUE_FULL;
                        n_out_id = '0;
                        n_state  = S_IDLE;
                    end else if (r_qcount == '0) begin
                        n_k     = '0;
                        n_pos   = '0;
                        n_state = S_SHIFT;
                    end else begin
                        n_k     = r_qcount;
                        n_state = S_QSRCH;
                    end
                end else if (r_pend && r_last) begin
                    n_pend   = 1'b0;
                    n_valid  = 1'b1;
                    n_status = ST_UNKNOWN;
                    n_out_id = '0;
                    n_state  = S_IDLE;
                end
            end
            S_QSRCH: begin
                q_raddr = slot_of(r_qhead, k_dec);
                if (r_k != '0) begin
                    n_pend = 1'b1;
                    n_pk   = r_k;
                    n_k    = k_dec;
                end
                if (r_pend && (q_rdata[GRP_W-1:0] == r_grp)) begin
                    n_pend  = 1'b0;
                    n_pos   = r_pk;
                    n_k     = r_qcount;
                    n_state = S_SHIFT;
                end else if (r_pend && (r_pk == QCW'(1))) begin
                    n_pend  = 1'b0;
                    n_pos   = r_qcount;
                    n_k     = r_qcount;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                q_raddr = slot_of(r_qhead, k_dec);
                if (r_pend) begin
                    q_we = 1'b1;
                end
                if (r_k != r_pos) begin
                    n_pend = 1'b1;
                    n_dst  = slot_of(r_qhead, r_k);
                    n_k    = k_dec;
                end else if (!r_pend) begin
                    q_we     = 1'b1;
                    q_waddr  = slot_of(r_qhead, r_pos);
                    q_wdata  = {r_id, r_grp};
                    n_qcount = r_qcount + QCW'(1);
                    n_state  = S_IDLE;
                end
            end
            S_DEQ: begin
                n_valid  = 1'b1;
                n_status = ST_DEQUEUED;
                n_out_id = q_rdata[ENTRY_W-1:GRP_W];
                n_qhead  = (r_qhead == QW'(QUEUE_DEPTH - 1)) ? '0 : r_qhead + QW'(1);
                n_qcount = r_qcount - QCW'(1);
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mcount <= '0;
            r_qhead  <= '0;
            r_qcount <= '0;
            r_pend   <= 1'b0;
            r_last   <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mcount <= n_mcount;
            r_qhead  <= n_qhead;
            r_qcount <= n_qcount;
            r_pend   <= n_pend;
            r_last   <= n_last;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id     <= n_id;
        r_grp    <= n_grp;
        r_ra     <= n_ra;
        r_k      <= n_k;
        r_pk     <= n_pk;
        r_pos    <= n_pos;
        r_dst    <= n_dst;
        r_status <= n_status;
        r_out_id <= n_out_id;
    end

    giq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MEMBER_DEPTH)
    ) u_member_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    giq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_out_id = r_out_id;

endmodule

/* sv/giq_checker.sv */
// Port-level checker for the grouped insert queue, bound to the top level.
module giq_checker import giq_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic [OP_W-1:0]     i_opcode,
    input logic                busy,
    input logic                o_valid,
    input logic [STATUS_W-1:0] o_status,
    input logic [ID_W-1:0]     o_out_id
);

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result word shown while the block is still busy");

    a_error_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_DEQUEUED)) |-> (o_out_id == '0))
        else $error("error word carries a non-zero id");

    a_register_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_REG)) |=> (!busy && (!o_valid ||
            (o_status == ST_MEMBER_FULL))))
        else $error("register item did not complete in one cycle");

    a_nop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_NOP)) |=> (!busy && !o_valid))
        else $error("unused opcode produced activity");

    a_member_full_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_MEMBER_FULL)) |->
            $past(start && !busy && (i_opcode == OP_REG)))
        else $error("member table full reported without a register item");

endmodule

bind grouped_insert_queue giq_checker u_giq_checker (.*);
